// ===== rtl/rcme_pkg.sv =====
// Shared types, widths, codes and step functions of the route cost matrix entry unit.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package rcme_pkg;

   localparam int NODE_W      = 8;
   localparam int COORD_W     = 24;
   localparam int WORKER_W    = 4;
   localparam int RATE_W      = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int COST_W      = 32;
   localparam int FRAC_W      = 8;

   localparam int MAX_NODES_DEF        = 256;
   localparam int MAX_WORKER_LIMIT_DEF = 15;

   localparam int DIST_W      = 25;
   localparam int SUMSQ_W     = 2 * DIST_W;
   localparam int SQ_REM_W    = DIST_W + 2;
   localparam int TRAVEL_W    = DIST_W + FRAC_W;
   localparam int PROD_W      = RATE_W + COORD_W - FRAC_W;
   localparam int SVC_W       = TRAVEL_W + 3;
   localparam int MAG_W       = SVC_W - 1;
   localparam int SUM_W       = SVC_W + 2;

   localparam logic [RATE_W-1:0]   SERVICE_RATE_RST   = RATE_W'(256);
   localparam logic [RATE_W-1:0]   TRUCK_VELOCITY_RST = RATE_W'(256);
   localparam logic [WORKER_W-1:0] MAX_WORKERS_RST    = WORKER_W'(15);

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_NOT_LOADED = 2'd1,
      STATUS_WORKERS    = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ADAPT_ENABLE   = 2'd0,
      CSR_SERVICE_RATE   = 2'd1,
      CSR_TRUCK_VELOCITY = 2'd2,
      CSR_MAX_WORKERS    = 2'd3
   } csr_index_type;

   typedef enum logic {
      FUNC_LOAD  = 1'b0,
      FUNC_QUERY = 1'b1
   } func_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] demand;
      logic [COORD_W-1:0] ready;
      logic [COORD_W-1:0] service;
   } node_rec_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } pos_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] due;
   } depot_type;

   typedef struct packed {
      status_type          status;
      logic                zero_cost;
      logic                use_adapt;
      logic                svc_neg;
      logic [WORKER_W-1:0] workers;
      logic [DIST_W-1:0]   dist_ij;
      logic [PROD_W-1:0]   by_rate;
      logic [COORD_W-1:0]  ready;
      logic [COORD_W-1:0]  due;
      logic [COORD_W-1:0]  service;
   } ctx_type;

   typedef struct packed {
      logic [SUMSQ_W-1:0]  v;
      logic [SQ_REM_W-1:0] rem;
      logic [DIST_W-1:0]   root;
   } sq_lane_type;

   typedef struct packed {
      logic [TRAVEL_W-1:0] nq;
      logic [RATE_W-1:0]   rem;
   } travel_type;

   typedef struct packed {
      logic [MAG_W-1:0]    nq;
      logic [WORKER_W-1:0] rem;
   } share_type;

   // One result bit of a restoring square root.
   function automatic sq_lane_type sqrt_step(sq_lane_type s);
      sq_lane_type         r;
      logic [SQ_REM_W+1:0] cur;
      logic [SQ_REM_W+1:0] trial;
      cur   = {s.rem, s.v[SUMSQ_W-1 -: 2]};
      trial = {2'b00, s.root, 2'b01};
      r.v   = {s.v[SUMSQ_W-3:0], 2'b00};
      if (cur >= trial) begin
         r.rem  = SQ_REM_W'(cur - trial);
         r.root = {s.root[DIST_W-2:0], 1'b1};
      end else begin
         r.rem  = SQ_REM_W'(cur);
         r.root = {s.root[DIST_W-2:0], 1'b0};
      end
      return r;
   endfunction

   // One quotient bit of the travel time division by the velocity.
   function automatic travel_type travel_step(travel_type s, logic [RATE_W-1:0] vel);
      travel_type        r;
      logic [RATE_W:0]   cur;
      logic              ge;
      cur   = {s.rem, s.nq[TRAVEL_W-1]};
      ge    = cur >= {1'b0, vel};
      r.nq  = {s.nq[TRAVEL_W-2:0], ge};
      r.rem = ge ? RATE_W'(cur - {1'b0, vel}) : RATE_W'(cur);
      return r;
   endfunction

   // One quotient bit of the service time division by the worker count.
   function automatic share_type share_step(share_type s, logic [WORKER_W-1:0] w);
      share_type         r;
      logic [WORKER_W:0] cur;
      logic              ge;
      cur   = {s.rem, s.nq[MAG_W-1]};
      ge    = cur >= {1'b0, w};
      r.nq  = {s.nq[MAG_W-2:0], ge};
      r.rem = ge ? WORKER_W'(cur - {1'b0, w}) : WORKER_W'(cur);
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/route_cost_matrix_entry_unit.sv =====
// Top level of the route cost matrix entry unit: node store, status checks and the
// pipelined distance, travel time and service share datapath. Depends on rcme_pkg.
//
// Usage: a transfer on the req_ channel with req_func = load writes one node record
// (node 0 is the depot) and gives no result. A transfer with req_func = query asks
// for the cost from req_node_index to req_to_node with req_worker_count workers and
// gives exactly one rsp_ transfer carrying a status and a signed Q31.0 cost.
// The user must have the csr_ port write the four settings only when the block is
// idle; the block itself does not enforce it. A query's result appears on rsp_valid
// after the input stages, the 25 root stages, the 33 stages of the velocity division,
// the 35 stages of the division by the worker count and the square and output
// stages. Throughput is one item per cycle while rsp_stall does not hold the pipeline;
// a load may be followed by a query of the same node in the next cycle.
// Reset clears the loaded flags and the pipeline valid bits and resets the settings;
// the node store itself keeps its contents and counts only once written.
// While rsp_valid is high and rsp_stall is high the whole pipeline holds and
// req_stall is raised; nothing is lost or repeated.
`default_nettype none

module route_cost_matrix_entry_unit #(
   parameter int MAX_NODES        = rcme_pkg::MAX_NODES_DEF,
   parameter int MAX_WORKER_LIMIT = rcme_pkg::MAX_WORKER_LIMIT_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_func,
   input  logic [rcme_pkg::NODE_W-1:0]        req_node_index,
   input  logic [rcme_pkg::COORD_W-1:0]       req_x_coord,
   input  logic [rcme_pkg::COORD_W-1:0]       req_y_coord,
   input  logic [rcme_pkg::COORD_W-1:0]       req_demand,
   input  logic [rcme_pkg::COORD_W-1:0]       req_ready_time,
   input  logic [rcme_pkg::COORD_W-1:0]       req_due_time,
   input  logic [rcme_pkg::COORD_W-1:0]       req_service_time,
   input  logic [rcme_pkg::NODE_W-1:0]        req_to_node,
   input  logic [rcme_pkg::WORKER_W-1:0]      req_worker_count,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic signed [rcme_pkg::COST_W-1:0] rsp_cost,
   input  logic                               csr_write,
   input  logic [rcme_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [rcme_pkg::RATE_W-1:0]        csr_data
);
   import rcme_pkg::*;

   localparam int ADDR_W       = $clog2(MAX_NODES);
   localparam int SQRT_STEPS   = DIST_W;
   localparam int TRAVEL_STEPS = TRAVEL_W;
   localparam int SHARE_STEPS  = MAG_W;

   logic                adapt_enable_ff;
   logic [RATE_W-1:0]   service_rate_ff;
   logic [RATE_W-1:0]   truck_velocity_ff;
   logic [WORKER_W-1:0] max_workers_ff;
   logic [RATE_W-1:0]   velocity;

   logic                advance;
   logic                accept;
   logic                load_wr;
   logic                i_in_range;
   logic                j_in_range;
   logic                ld_i;
   logic                ld_j;
   logic                same_node;
   logic                src_depot;
   logic [ADDR_W-1:0]   addr_i;
   logic [ADDR_W-1:0]   addr_j;
   status_type          status_in;

   logic [MAX_NODES-1:0] loaded_ff;
   node_rec_type         node_mem_ff [MAX_NODES];
   pos_type              pos_mem_ff [MAX_NODES];
   depot_type            depot_ff;

   logic                 s1_valid_ff;
   ctx_type              s1_ctx_ff;
   ctx_type              s1_ctx_in;
   node_rec_type         rd_i_ff;
   pos_type              rd_j_ff;
   depot_type            s1_depot_ff;

   logic                 s2_valid_ff;
   ctx_type              s2_ctx_ff;
   ctx_type              s2_ctx_in;
   logic [COORD_W-1:0]   s2_demand_ff;
   logic [COORD_W-1:0]   dx_ij_ff;
   logic [COORD_W-1:0]   dy_ij_ff;
   logic [COORD_W-1:0]   dx_0i_ff;
   logic [COORD_W-1:0]   dy_0i_ff;

   logic                 s3_valid_ff;
   ctx_type              s3_ctx_ff;
   ctx_type              s3_ctx_in;
   logic [2*COORD_W-1:0] sqx_ij_ff;
   logic [2*COORD_W-1:0] sqy_ij_ff;
   logic [2*COORD_W-1:0] sqx_0i_ff;
   logic [2*COORD_W-1:0] sqy_0i_ff;
   logic [2*COORD_W-1:0] rate_prod;

   logic                 sq_valid_ff [SQRT_STEPS+1];
   ctx_type              sq_ctx_ff [SQRT_STEPS+1];
   sq_lane_type          sq_ij_ff [SQRT_STEPS+1];
   sq_lane_type          sq_0i_ff [SQRT_STEPS+1];

   logic                 tr_valid_ff [TRAVEL_STEPS+1];
   ctx_type              tr_ctx_ff [TRAVEL_STEPS+1];
   ctx_type              tr_ctx_in;
   travel_type           tr_ff [TRAVEL_STEPS+1];

   logic                 e1_valid_ff;
   ctx_type              e1_ctx_ff;
   logic signed [SVC_W-1:0] e1_window_ff;
   logic signed [SVC_W-1:0] e1_window_in;
   logic [TRAVEL_W-1:0]  travel;
   logic [TRAVEL_W-1:0]  start;

   logic signed [SVC_W-1:0] by_rate_s;
   logic signed [SVC_W-1:0] svc;
   logic signed [SVC_W-1:0] svc_abs;

   logic                 sh_valid_ff [SHARE_STEPS+1];
   ctx_type              sh_ctx_ff [SHARE_STEPS+1];
   ctx_type              sh_ctx_in;
   share_type            sh_ff [SHARE_STEPS+1];

   logic                 f1_valid_ff;
   ctx_type              f1_ctx_ff;
   logic signed [SVC_W-1:0] f1_term_ff;
   logic signed [SVC_W-1:0] f1_term_in;
   logic signed [SVC_W-1:0] quot_s;

   logic signed [SUM_W-1:0]   f2_sum;
   logic [SUM_W-COST_W:0]     sum_top;
   logic signed [COST_W-1:0]  cost_in;

   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   logic signed [COST_W-1:0] rsp_cost_ff;

   // Settings.
   always_ff @(posedge clock) begin
      if (reset) begin
         adapt_enable_ff   <= 1'b0;
         service_rate_ff   <= SERVICE_RATE_RST;
         truck_velocity_ff <= TRUCK_VELOCITY_RST;
         max_workers_ff    <= MAX_WORKERS_RST;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_ADAPT_ENABLE:   adapt_enable_ff   <= csr_data[0];
            CSR_SERVICE_RATE:   service_rate_ff   <= csr_data;
            CSR_TRUCK_VELOCITY: truck_velocity_ff <= csr_data;
            CSR_MAX_WORKERS:    max_workers_ff    <= csr_data[WORKER_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign velocity = (truck_velocity_ff == '0) ? RATE_W'(1) : truck_velocity_ff;

   // Input side and checks.
   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !advance;
   assign accept     = req_valid && advance;
   assign i_in_range = int'(req_node_index) < MAX_NODES;
   assign j_in_range = int'(req_to_node) < MAX_NODES;
   assign addr_i     = ADDR_W'(req_node_index);
   assign addr_j     = ADDR_W'(req_to_node);
   assign load_wr    = accept && (func_type'(req_func) == FUNC_LOAD) && i_in_range;
   assign ld_i       = i_in_range && loaded_ff[addr_i];
   assign ld_j       = j_in_range && loaded_ff[addr_j];
   assign same_node  = req_node_index == req_to_node;
   assign src_depot  = req_node_index == '0;

   always_comb begin
      if (!ld_i || !ld_j) begin
         status_in = STATUS_NOT_LOADED;
      end else if (adapt_enable_ff && (req_worker_count != '0) && !src_depot && !same_node
                   && !loaded_ff[0]) begin
         status_in = STATUS_NOT_LOADED;
      end else if ((req_worker_count > max_workers_ff)
                   || (int'(req_worker_count) > MAX_WORKER_LIMIT)) begin
         status_in = STATUS_WORKERS;
      end else begin
         status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
      end else if (load_wr) begin
         loaded_ff[addr_i] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load_wr) begin
         node_mem_ff[addr_i] <= '{x: req_x_coord, y: req_y_coord, demand: req_demand,
                                  ready: req_ready_time, service: req_service_time};
         pos_mem_ff[addr_i]  <= '{x: req_x_coord, y: req_y_coord};
      end
      if (load_wr && src_depot) begin
         depot_ff <= '{x: req_x_coord, y: req_y_coord, due: req_due_time};
      end
      if (advance) begin
         rd_i_ff     <= node_mem_ff[addr_i];
         rd_j_ff     <= pos_mem_ff[addr_j];
         s1_depot_ff <= depot_ff;
      end
   end

   // Pipeline valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         e1_valid_ff  <= 1'b0;
         f1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k <= SQRT_STEPS; k++) begin
            sq_valid_ff[k] <= 1'b0;
         end
         for (int k = 0; k <= TRAVEL_STEPS; k++) begin
            tr_valid_ff[k] <= 1'b0;
         end
         for (int k = 0; k <= SHARE_STEPS; k++) begin
            sh_valid_ff[k] <= 1'b0;
         end
      end else if (advance) begin
         s1_valid_ff    <= accept && (func_type'(req_func) == FUNC_QUERY);
         s2_valid_ff    <= s1_valid_ff;
         s3_valid_ff    <= s2_valid_ff;
         sq_valid_ff[0] <= s3_valid_ff;
         for (int k = 0; k < SQRT_STEPS; k++) begin
            sq_valid_ff[k+1] <= sq_valid_ff[k];
         end
         tr_valid_ff[0] <= sq_valid_ff[SQRT_STEPS];
         for (int k = 0; k < TRAVEL_STEPS; k++) begin
            tr_valid_ff[k+1] <= tr_valid_ff[k];
         end
         e1_valid_ff    <= tr_valid_ff[TRAVEL_STEPS];
         sh_valid_ff[0] <= e1_valid_ff;
         for (int k = 0; k < SHARE_STEPS; k++) begin
            sh_valid_ff[k+1] <= sh_valid_ff[k];
         end
         f1_valid_ff  <= sh_valid_ff[SHARE_STEPS];
         rsp_valid_ff <= f1_valid_ff;
      end
   end

   // Front stages: differences, squares, sums.
   assign rate_prod = (2*COORD_W)'(service_rate_ff) * (2*COORD_W)'(s2_demand_ff);

   always_comb begin
      s1_ctx_in           = '0;
      s1_ctx_in.status    = status_in;
      s1_ctx_in.zero_cost = (status_in != STATUS_OK) || same_node;
      s1_ctx_in.use_adapt = adapt_enable_ff && !src_depot;
      s1_ctx_in.workers   = req_worker_count;

      s2_ctx_in         = s1_ctx_ff;
      s2_ctx_in.ready   = rd_i_ff.ready;
      s2_ctx_in.service = rd_i_ff.service;
      s2_ctx_in.due     = s1_depot_ff.due;

      s3_ctx_in         = s2_ctx_ff;
      s3_ctx_in.by_rate = rate_prod[FRAC_W +: PROD_W];

      tr_ctx_in         = sq_ctx_ff[SQRT_STEPS];
      tr_ctx_in.dist_ij = sq_ij_ff[SQRT_STEPS].root;

      sh_ctx_in         = e1_ctx_ff;
      sh_ctx_in.svc_neg = svc[SVC_W-1];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ctx_ff <= s1_ctx_in;

         s2_ctx_ff    <= s2_ctx_in;
         s2_demand_ff <= rd_i_ff.demand;
         dx_ij_ff <= (rd_i_ff.x > rd_j_ff.x) ? rd_i_ff.x - rd_j_ff.x : rd_j_ff.x - rd_i_ff.x;
         dy_ij_ff <= (rd_i_ff.y > rd_j_ff.y) ? rd_i_ff.y - rd_j_ff.y : rd_j_ff.y - rd_i_ff.y;
         dx_0i_ff <= (rd_i_ff.x > s1_depot_ff.x) ? rd_i_ff.x - s1_depot_ff.x
                                                 : s1_depot_ff.x - rd_i_ff.x;
         dy_0i_ff <= (rd_i_ff.y > s1_depot_ff.y) ? rd_i_ff.y - s1_depot_ff.y
                                                 : s1_depot_ff.y - rd_i_ff.y;

         s3_ctx_ff <= s3_ctx_in;
         sqx_ij_ff <= (2*COORD_W)'(dx_ij_ff) * (2*COORD_W)'(dx_ij_ff);
         sqy_ij_ff <= (2*COORD_W)'(dy_ij_ff) * (2*COORD_W)'(dy_ij_ff);
         sqx_0i_ff <= (2*COORD_W)'(dx_0i_ff) * (2*COORD_W)'(dx_0i_ff);
         sqy_0i_ff <= (2*COORD_W)'(dy_0i_ff) * (2*COORD_W)'(dy_0i_ff);
      end
   end

   // Square root stages, one result bit each, two lanes.
   always_ff @(posedge clock) begin
      if (advance) begin
         sq_ctx_ff[0] <= s3_ctx_ff;
         sq_ij_ff[0]  <= '{v: SUMSQ_W'(sqx_ij_ff) + SUMSQ_W'(sqy_ij_ff), rem: '0, root: '0};
         sq_0i_ff[0]  <= '{v: SUMSQ_W'(sqx_0i_ff) + SUMSQ_W'(sqy_0i_ff), rem: '0, root: '0};
         for (int k = 0; k < SQRT_STEPS; k++) begin
            sq_ctx_ff[k+1] <= sq_ctx_ff[k];
            sq_ij_ff[k+1]  <= sqrt_step(sq_ij_ff[k]);
            sq_0i_ff[k+1]  <= sqrt_step(sq_0i_ff[k]);
         end
      end
   end

   // Travel time stages: depot distance times 256 over the velocity.
   always_ff @(posedge clock) begin
      if (advance) begin
         tr_ctx_ff[0] <= tr_ctx_in;
         tr_ff[0]     <= '{nq: {sq_0i_ff[SQRT_STEPS].root, {FRAC_W{1'b0}}}, rem: '0};
         for (int k = 0; k < TRAVEL_STEPS; k++) begin
            tr_ctx_ff[k+1] <= tr_ctx_ff[k];
            tr_ff[k+1]     <= travel_step(tr_ff[k], velocity);
         end
      end
   end

   // Adapted service time and its sign and magnitude.
   assign travel = tr_ff[TRAVEL_STEPS].nq;
   assign start  = (TRAVEL_W'(tr_ctx_ff[TRAVEL_STEPS].ready) > travel)
                   ? TRAVEL_W'(tr_ctx_ff[TRAVEL_STEPS].ready) : travel;
   assign e1_window_in = $signed(SVC_W'(tr_ctx_ff[TRAVEL_STEPS].due) - SVC_W'(start)
                                 - SVC_W'(travel));

   assign by_rate_s = $signed(SVC_W'(e1_ctx_ff.by_rate));
   assign svc = !e1_ctx_ff.use_adapt ? $signed(SVC_W'(e1_ctx_ff.service))
                : ((by_rate_s < e1_window_ff) ? by_rate_s : e1_window_ff);
   assign svc_abs = svc[SVC_W-1] ? -svc : svc;

   always_ff @(posedge clock) begin
      if (advance) begin
         e1_ctx_ff    <= tr_ctx_ff[TRAVEL_STEPS];
         e1_window_ff <= e1_window_in;

         sh_ctx_ff[0] <= sh_ctx_in;
         sh_ff[0]     <= '{nq: MAG_W'(svc_abs), rem: '0};
         for (int k = 0; k < SHARE_STEPS; k++) begin
            sh_ctx_ff[k+1] <= sh_ctx_ff[k];
            sh_ff[k+1]     <= share_step(sh_ff[k], sh_ctx_ff[k].workers);
         end
      end
   end

   // Output: sign, sum with the distance, saturation.
   assign quot_s     = $signed(SVC_W'(sh_ff[SHARE_STEPS].nq));
   assign f1_term_in = (sh_ctx_ff[SHARE_STEPS].workers == '0) ? '0
                       : (sh_ctx_ff[SHARE_STEPS].svc_neg ? -quot_s : quot_s);

   assign f2_sum  = $signed(SUM_W'(f1_ctx_ff.dist_ij)) + SUM_W'(f1_term_ff);
   assign sum_top = f2_sum[SUM_W-1:COST_W-1];

   always_comb begin
      if (f1_ctx_ff.zero_cost) begin
         cost_in = '0;
      end else if ((&sum_top) || !(|sum_top)) begin
         cost_in = f2_sum[COST_W-1:0];
      end else if (f2_sum[SUM_W-1]) begin
         cost_in = {1'b1, {(COST_W-1){1'b0}}};
      end else begin
         cost_in = {1'b0, {(COST_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f1_ctx_ff     <= sh_ctx_ff[SHARE_STEPS];
         f1_term_ff    <= f1_term_in;
         rsp_status_ff <= f1_ctx_ff.status;
         rsp_cost_ff   <= cost_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_cost   = rsp_cost_ff;

   // An error result always carries a zero cost.
   a_error_zero_cost: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status_ff != STATUS_OK)) |-> (rsp_cost == '0))
      else $error("error result with nonzero cost");

   // A load transfer never enters the result pipeline.
   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (accept && (func_type'(req_func) == FUNC_LOAD)) |=> !s1_valid_ff)
      else $error("load entered the result pipeline");

   // The depot's loaded flag only clears on reset.
   a_depot_loaded_kept: assert property (@(posedge clock) disable iff (reset)
      loaded_ff[0] |=> loaded_ff[0])
      else $error("depot loaded flag dropped");

endmodule

`default_nettype wire

// ===== test/route_cost_matrix_entry_checker.sv =====
// Checker for the route cost matrix entry unit: watches the csr_, req_ and rsp_ ports,
// predicts every query result and compares it with the rsp_ transfers. Depends on rcme_pkg.
module route_cost_matrix_entry_checker
   import rcme_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_stall,
   input  logic                      req_func,
   input  logic [NODE_W-1:0]         req_node_index,
   input  logic [COORD_W-1:0]        req_x_coord,
   input  logic [COORD_W-1:0]        req_y_coord,
   input  logic [COORD_W-1:0]        req_demand,
   input  logic [COORD_W-1:0]        req_ready_time,
   input  logic [COORD_W-1:0]        req_due_time,
   input  logic [COORD_W-1:0]        req_service_time,
   input  logic [NODE_W-1:0]         req_to_node,
   input  logic [WORKER_W-1:0]       req_worker_count,
   input  logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic [1:0]                rsp_status,
   input  logic signed [COST_W-1:0]  rsp_cost,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [RATE_W-1:0]         csr_data,
   output int                        failures,
   output int                        pending,
   output int                        loads_seen,
   output int                        ok_seen,
   output int                        unloaded_seen,
   output int                        workers_seen
);

   typedef struct {
      status_type               status;
      logic signed [COST_W-1:0] cost;
   } cost_entry_type;

   logic [COORD_W-1:0] node_x       [MAX_NODES_DEF];
   logic [COORD_W-1:0] node_y       [MAX_NODES_DEF];
   logic [COORD_W-1:0] node_demand  [MAX_NODES_DEF];
   logic [COORD_W-1:0] node_ready   [MAX_NODES_DEF];
   logic [COORD_W-1:0] node_due     [MAX_NODES_DEF];
   logic [COORD_W-1:0] node_service [MAX_NODES_DEF];
   logic               node_loaded  [MAX_NODES_DEF];

   logic              adapt_on;
   logic [RATE_W-1:0] rate_setting;
   logic [RATE_W-1:0] velocity_setting;
   logic [WORKER_W-1:0] worker_limit;

   cost_entry_type expected_costs [$];

   function automatic longint floor_root(longint v);
      longint r;
      longint cand;
      r = 0;
      for (int b = 25; b >= 0; b--) begin
         cand = r | (longint'(1) << b);
         if (cand * cand <= v) r = cand;
      end
      return r;
   endfunction

   function automatic longint distance(int a, int b);
      longint dx;
      longint dy;
      dx = longint'(node_x[a]) - longint'(node_x[b]);
      dy = longint'(node_y[a]) - longint'(node_y[b]);
      return floor_root(dx * dx + dy * dy);
   endfunction

   function automatic longint effective_service(int i);
      longint vel;
      longint travel;
      longint start;
      longint by_rate;
      longint by_window;
      if (!adapt_on || i == 0) return longint'(node_service[i]);
      vel = (velocity_setting == 0) ? 1 : longint'(velocity_setting);
      travel = (distance(0, i) << 8) / vel;
      start = (longint'(node_ready[i]) > travel) ? longint'(node_ready[i]) : travel;
      by_rate = (longint'(rate_setting) * longint'(node_demand[i])) >>> 8;
      by_window = longint'(node_due[0]) - start - travel;
      return (by_rate < by_window) ? by_rate : by_window;
   endfunction

   function automatic cost_entry_type predict_entry(int i, int j, int w);
      cost_entry_type e;
      longint c;
      e.status = STATUS_OK;
      e.cost = '0;
      if (!node_loaded[i] || !node_loaded[j]) begin
         e.status = STATUS_NOT_LOADED;
      end else if (adapt_on && w > 0 && i != 0 && i != j && !node_loaded[0]) begin
         e.status = STATUS_NOT_LOADED;
      end else if (w > worker_limit || w > MAX_WORKER_LIMIT_DEF) begin
         e.status = STATUS_WORKERS;
      end else if (i != j) begin
         c = distance(i, j);
         if (w > 0) c = c + effective_service(i) / longint'(w);
         if (c > 64'sd2147483647) c = 64'sd2147483647;
         if (c < -64'sd2147483648) c = -64'sd2147483648;
         e.cost = c[COST_W-1:0];
      end
      return e;
   endfunction

   always @(posedge clock) begin
      cost_entry_type exp_e;
      if (reset) begin
         for (int n = 0; n < MAX_NODES_DEF; n++) node_loaded[n] = 1'b0;
         adapt_on = 1'b0;
         rate_setting = SERVICE_RATE_RST;
         velocity_setting = TRUCK_VELOCITY_RST;
         worker_limit = MAX_WORKERS_RST;
         expected_costs.delete();
         pending = 0;
         failures = 0;
         loads_seen = 0;
         ok_seen = 0;
         unloaded_seen = 0;
         workers_seen = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_costs.size() == 0) begin
               $error("result transfer with no query outstanding");
               failures++;
            end else begin
               exp_e = expected_costs.pop_front();
               if (rsp_status !== exp_e.status) begin
                  $error("status expected %0d actual %0d", exp_e.status, rsp_status);
                  failures++;
               end
               if (rsp_cost !== exp_e.cost) begin
                  $error("cost expected %0d actual %0d", exp_e.cost, rsp_cost);
                  failures++;
               end
               case (exp_e.status)
                  STATUS_OK: ok_seen++;
                  STATUS_NOT_LOADED: unloaded_seen++;
                  default: workers_seen++;
               endcase
            end
         end
         if (csr_write) begin
            case (csr_index_type'(csr_index))
               CSR_ADAPT_ENABLE:   adapt_on = csr_data[0];
               CSR_SERVICE_RATE:   rate_setting = csr_data;
               CSR_TRUCK_VELOCITY: velocity_setting = csr_data;
               CSR_MAX_WORKERS:    worker_limit = csr_data[WORKER_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (func_type'(req_func) == FUNC_LOAD) begin
               node_x[req_node_index] = req_x_coord;
               node_y[req_node_index] = req_y_coord;
               node_demand[req_node_index] = req_demand;
               node_ready[req_node_index] = req_ready_time;
               node_due[req_node_index] = req_due_time;
               node_service[req_node_index] = req_service_time;
               node_loaded[req_node_index] = 1'b1;
               loads_seen++;
            end else begin
               expected_costs.push_back(predict_entry(int'(req_node_index),
                  int'(req_to_node), int'(req_worker_count)));
            end
         end
         pending = expected_costs.size();
      end
   end

endmodule

// ===== test/tb_route_cost_matrix_entry_unit.sv =====
// Top of the route cost matrix entry unit testbench: clock, reset, settings phases,
// directed and random node loads and queries, stalls. Depends on rcme_pkg and the checker.
module tb_route_cost_matrix_entry_unit;
   import rcme_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_func = 1'b0;
   logic [NODE_W-1:0] req_node_index = '0;
   logic [COORD_W-1:0] req_x_coord = '0;
   logic [COORD_W-1:0] req_y_coord = '0;
   logic [COORD_W-1:0] req_demand = '0;
   logic [COORD_W-1:0] req_ready_time = '0;
   logic [COORD_W-1:0] req_due_time = '0;
   logic [COORD_W-1:0] req_service_time = '0;
   logic [NODE_W-1:0] req_to_node = '0;
   logic [WORKER_W-1:0] req_worker_count = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic signed [COST_W-1:0] rsp_cost;
   logic csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [RATE_W-1:0] csr_data = '0;

   int failures, pending, loads_seen, ok_seen, unloaded_seen, workers_seen;
   int cycle_count = 0;
   bit sender_calm = 1'b0;

   route_cost_matrix_entry_unit dut (.*);

   route_cost_matrix_entry_checker checker_i (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > 200000) begin
         $display("tb_route_cost_matrix_entry_unit: FAIL");
         $finish;
      end
   end

   // The receiver holds off for a long stretch once and never holds off in another.
   always @(negedge clock) begin
      if (cycle_count >= 1500 && cycle_count < 1900) rsp_stall = 1'b1;
      else if (cycle_count >= 3000 && cycle_count < 3500) rsp_stall = 1'b0;
      else rsp_stall = ($urandom_range(99) < 37);
   end

   task automatic transfer(logic func, int node, int to, int w, logic [COORD_W-1:0] x,
                           logic [COORD_W-1:0] y, logic [COORD_W-1:0] dem,
                           logic [COORD_W-1:0] rdy, logic [COORD_W-1:0] due,
                           logic [COORD_W-1:0] svc);
      @(negedge clock);
      while (!sender_calm && $urandom_range(99) < 37) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_func = func;
      req_node_index = node[NODE_W-1:0];
      req_to_node = to[NODE_W-1:0];
      req_worker_count = w[WORKER_W-1:0];
      req_x_coord = x;
      req_y_coord = y;
      req_demand = dem;
      req_ready_time = rdy;
      req_due_time = due;
      req_service_time = svc;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic load_node(int node, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                            logic [COORD_W-1:0] dem, logic [COORD_W-1:0] rdy,
                            logic [COORD_W-1:0] due, logic [COORD_W-1:0] svc);
      transfer(FUNC_LOAD, node, $urandom_range(255), $urandom_range(15), x, y, dem, rdy,
               due, svc);
   endtask

   task automatic query(int i, int j, int w);
      transfer(FUNC_QUERY, i, j, w, COORD_W'($urandom), COORD_W'($urandom),
               COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
               COORD_W'($urandom));
   endtask

   task automatic write_setting(csr_index_type idx, logic [RATE_W-1:0] value);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic settle_and_configure(logic adapt, logic [RATE_W-1:0] rate,
                                       logic [RATE_W-1:0] vel, logic [WORKER_W-1:0] maxw);
      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (110) @(posedge clock);
      write_setting(CSR_ADAPT_ENABLE, RATE_W'(adapt));
      write_setting(CSR_SERVICE_RATE, rate);
      write_setting(CSR_TRUCK_VELOCITY, vel);
      write_setting(CSR_MAX_WORKERS, RATE_W'(maxw));
   endtask

   function automatic logic [COORD_W-1:0] pick_value();
      case ($urandom_range(4))
         0: return '0;
         1: return '1;
         2: return COORD_W'($urandom_range(4095));
         3: return COORD_W'($urandom_range(1 << 20));
         default: return COORD_W'($urandom);
      endcase
   endfunction

   function automatic int pick_node();
      return ($urandom_range(99) < 85) ? $urandom_range(15) : $urandom_range(255);
   endfunction

   task automatic random_items(int count);
      for (int k = 0; k < count; k++) begin
         if ($urandom_range(99) < 30)
            load_node(pick_node(), pick_value(), pick_value(), pick_value(), pick_value(),
                      pick_value(), pick_value());
         else
            query(pick_node(), pick_node(), $urandom_range(15));
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: unloaded nodes, missing depot under adaptation, diagonal, extremes.
      settle_and_configure(1'b1, 16'hFFFF, 16'h0000, 4'd15);
      query(1, 2, 0);
      query(255, 0, 15);
      load_node(1, '1, '1, '1, '1, '1, '1);
      load_node(2, '0, '0, '0, '0, '0, '0);
      query(1, 2, 3);
      query(1, 1, 3);
      query(1, 2, 0);
      load_node(0, 24'd1000, 24'd2000, 24'd0, 24'd0, 24'd500, 24'd300);
      query(1, 2, 1);
      query(1, 2, 15);
      query(2, 1, 1);
      query(0, 1, 15);
      query(1, 0, 7);
      load_node(3, 24'd4096, 24'd0, 24'd10, 24'd0, '1, 24'd256);
      query(3, 0, 1);
      query(3, 3, 0);
      query(3, 200, 2);
      load_node(255, '0, '1, 24'd1, '1, '0, '1);
      query(255, 1, 1);
      query(0, 0, 0);

      settle_and_configure(1'b0, 16'd256, 16'd256, 4'd15);
      random_items(340);
      settle_and_configure(1'b1, 16'd0, 16'hFFFF, 4'd0);
      random_items(340);
      settle_and_configure(1'b1, 16'd256, 16'd1, 4'd7);
      sender_calm = 1'b1;
      random_items(340);
      sender_calm = 1'b0;
      settle_and_configure(1'($urandom), 16'($urandom), 16'($urandom),
                           4'($urandom_range(15)));
      random_items(340);
      settle_and_configure(1'b1, 16'hFFFF, 16'hFFFF, 4'd15);
      random_items(340);

      @(negedge clock);
      req_valid = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (120) @(posedge clock);
      $display("Covered %0d node loads and %0d queries over six settings phases.",
               loads_seen, ok_seen + unloaded_seen + workers_seen);
      $display("Query outcomes: %0d ok, %0d node not loaded, %0d too many workers.",
               ok_seen, unloaded_seen, workers_seen);
      if (failures == 0) begin
         $display("tb_route_cost_matrix_entry_unit: PASS");
      end else begin
         $display("tb_route_cost_matrix_entry_unit: FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/rcme_pkg.sv
rtl/route_cost_matrix_entry_unit.sv
test/route_cost_matrix_entry_checker.sv
test/tb_route_cost_matrix_entry_unit.sv
